@@ design/tln_pkg.sv @@
// Shared types, constants and codes for the truncated Laplace noise block.
package tln_pkg;

	// Latency of the log pipeline, from input register to result register
	localparam int SQ_STEPS = 32;
	localparam int LOG_LAT  = SQ_STEPS + 6;

	// Fixed-point constants
	localparam logic [63:0] LN2_Q64      = 64'hB17217F7D1CF79AB;
	localparam logic [31:0] LN2_Q32      = 32'd2977044471;
	localparam logic [63:0] EXP_CUTOFF   = 64'd23 << 32;
	localparam logic [30:0] DRAW_LIMIT   = 31'h7FFF_FFFF;
	localparam logic [3:0]  TAYLOR_TERMS = 4'd14;
	localparam logic [62:0] MAG_CAP      = 63'd1 << 62;
	localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;

	// Register indexes
	localparam logic [1:0] CFG_EPSILON = 2'd0;
	localparam logic [1:0] CFG_DELTA   = 2'd1;
	localparam logic [1:0] CFG_SENS    = 2'd2;

	// Register reset values
	localparam logic [23:0] RST_EPSILON = 24'd65536;
	localparam logic [31:0] RST_DELTA   = 32'd42950;
	localparam logic [31:0] RST_SENS    = 32'd65536;

	typedef struct packed {
		logic signed [31:0] uniform_draw;
		logic [31:0]        exact_count;
	} tln_in_t;

	typedef struct packed {
		logic [31:0] noise_value;
		logic [32:0] noisy_count;
		logic        noise_saturated;
	} tln_out_t;

	// Per-draw side data that travels beside the log pipeline
	typedef struct packed {
		logic        uneg;
		logic        nz;
		logic [31:0] count;
	} tln_side_t;

	// Terms that depend on configuration only
	typedef struct packed {
		logic signed [63:0] num_base;
		logic [63:0]        scale;
		logic signed [63:0] base;
	} tln_consts_t;

endpackage

@@ design/truncated_laplace_noise_count.sv @@
// Top level of the truncated Laplace noise block for result counts.
//
// Input channel in_valid/in_stall/in_item carries a uniform draw (signed
// Q0.32) and a true count; a transaction is taken when in_valid is high and
// in_stall is low. Output channel out_valid/out_stall/out_item returns the
// rounded, zero-clamped noise, the noisy count and a saturation flag, one
// result per draw, in order.
// A draw passes the input register, the log and the scaling pipeline before
// out_valid rises; the fully pipelined datapath takes one draw every
// cycle while in_stall is low. The cfg_valid/cfg_ready/cfg_index/cfg_data
// port writes epsilon, delta and sensitivity; cfg_ready is always high. The
// user must make writes go in while idle; the block does not enforce it.
// After reset and each write it derives its shift, scale and soft terms
// with an iterative divider and the log unit; in_stall is high until done.
// When out_stall is high with a result waiting, the whole pipeline holds,
// the output register keeps its transaction, and in_stall rises.
module truncated_laplace_noise_count import tln_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  tln_in_t     in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output tln_out_t    out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic               en;
	logic               consts_ready;
	tln_consts_t        consts;
	logic               v_s1;
	logic [31:0]        draw_s1;
	logic [31:0]        cnt_s1;
	tln_side_t          side_q [LOG_LAT];
	logic [31:0]        umag_full_c;
	logic [30:0]        umag_c;
	logic [33:0]        x_c;
	tln_side_t          side_c;
	logic               log_valid;
	logic signed [63:0] log_ln;

	// Advance whenever the output register is free or being taken
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en || !consts_ready;

	tln_consts u_consts (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.consts    (consts),
		.ready     (consts_ready)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && consts_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			draw_s1 <= in_item.uniform_draw;
			cnt_s1  <= in_item.exact_count;
		end
	end

	// Magnitude of the draw, limited so 1 - 2|u| stays positive
	always_comb begin
		umag_full_c  = draw_s1[31] ? (~draw_s1 + 32'd1) : draw_s1;
		umag_c       = (umag_full_c > {1'b0, DRAW_LIMIT}) ? DRAW_LIMIT : umag_full_c[30:0];
		x_c          = 34'(ONE_Q32) - {2'b0, umag_c, 1'b0};
		side_c.uneg  = draw_s1[31];
		side_c.nz    = (umag_c != '0);
		side_c.count = cnt_s1;
	end

	tln_log u_log (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.x         (x_c),
		.out_valid (log_valid),
		.ln        (log_ln)
	);

	// Delay the side data to line up with the log result
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_c;
			for (int i = 1; i < LOG_LAT; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	tln_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (log_valid),
		.ln_m      (log_ln),
		.side      (side_q[LOG_LAT-1]),
		.consts    (consts),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

endmodule

@@ design/tln_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
module tln_div import tln_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] num_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [32:0] trial_c;
	logic [32:0] diff_c;
	logic        ge_c;

	// Trial subtract of the next partial remainder
	always_comb begin
		trial_c = {rem_q, num_q[63]};
		diff_c  = trial_c - {1'b0, dsr_q};
		ge_c    = trial_c >= {1'b0, dsr_q};
	end

	// Control: start reloads at any time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd63);
			if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: shift quotient bits in as the dividend shifts out
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], ge_c};
			rem_q <= ge_c ? diff_c[31:0] : trial_c[31:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

@@ design/tln_log.sv @@
// Pipelined natural log of an unsigned Q2.32 value by repeated squaring.
module tln_log import tln_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [33:0]        x,
	output logic               out_valid,
	output logic signed [63:0] ln
);

	logic               v_s1, v_s2, v_s3, v_s5, v_s6, v_s7;
	logic [33:0]        x_s1, x_s2;
	logic [5:0]         p_s2, p_s3;
	logic [31:0]        m_s3;
	logic               sv_s4 [SQ_STEPS];
	logic [31:0]        sm_s4 [SQ_STEPS];
	logic [31:0]        sf_s4 [SQ_STEPS];
	logic [5:0]         sp_s4 [SQ_STEPS];
	logic [37:0]        mag_s5;
	logic               neg_s5, neg_s6;
	logic [69:0]        ph_s6, pl_s6;
	logic signed [63:0] ln_s7;

	logic [5:0]         p_c;
	logic [63:0]        wide_c;
	logic               vi_c [SQ_STEPS];
	logic [31:0]        mi_c [SQ_STEPS];
	logic [31:0]        fi_c [SQ_STEPS];
	logic [5:0]         pi_c [SQ_STEPS];
	logic [63:0]        sq_c [SQ_STEPS];
	logic signed [6:0]  int_c;
	logic signed [38:0] l2_c;
	logic signed [38:0] abs_c;
	logic [101:0]       full_c;
	logic [37:0]        hi_c;

	// Find the leading one
	always_comb begin
		p_c = '0;
		for (int i = 0; i < 34; i++) begin
			if (x_s1[i]) begin
				p_c = 6'(i);
			end
		end
	end

	// Left-justify to Q1.31
	always_comb begin
		wide_c = {30'b0, x_s2} << (6'd63 - p_s2);
	end

	// Square and renormalize, one fraction bit per step
	always_comb begin
		for (int k = 0; k < SQ_STEPS; k++) begin
			if (k == 0) begin
				vi_c[k] = v_s3;
				mi_c[k] = m_s3;
				fi_c[k] = '0;
				pi_c[k] = p_s3;
			end else begin
				vi_c[k] = sv_s4[k-1];
				mi_c[k] = sm_s4[k-1];
				fi_c[k] = sf_s4[k-1];
				pi_c[k] = sp_s4[k-1];
			end
			sq_c[k] = {32'b0, mi_c[k]} * {32'b0, mi_c[k]};
		end
	end

	// Build log2 and take its magnitude
	always_comb begin
		int_c  = $signed({1'b0, sp_s4[SQ_STEPS-1]}) - 7'sd32;
		l2_c   = {int_c, sf_s4[SQ_STEPS-1]};
		abs_c  = l2_c[38] ? -l2_c : l2_c;
		full_c = {ph_s6, 32'b0} + {32'b0, pl_s6};
		hi_c   = full_c[101:64];
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int k = 0; k < SQ_STEPS; k++) begin
				sv_s4[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			for (int k = 0; k < SQ_STEPS; k++) begin
				sv_s4[k] <= vi_c[k];
			end
			v_s5 <= sv_s4[SQ_STEPS-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= (x == '0) ? 34'd1 : x;
			x_s2 <= x_s1;
			p_s2 <= p_c;
			m_s3 <= wide_c[63:32];
			p_s3 <= p_s2;
			for (int k = 0; k < SQ_STEPS; k++) begin
				sm_s4[k] <= sq_c[k][63] ? sq_c[k][63:32] : sq_c[k][62:31];
				sf_s4[k] <= fi_c[k] | (sq_c[k][63] ? (32'h8000_0000 >> k) : 32'h0);
				sp_s4[k] <= pi_c[k];
			end
			mag_s5 <= abs_c[37:0];
			neg_s5 <= l2_c[38];
			ph_s6  <= 70'(mag_s5) * 70'(LN2_Q64[63:32]);
			pl_s6  <= 70'(mag_s5) * 70'(LN2_Q64[31:0]);
			neg_s6 <= neg_s5;
			ln_s7  <= neg_s6 ? -$signed(64'(hi_c)) : $signed(64'(hi_c));
		end
	end

	assign out_valid = v_s7;
	assign ln        = ln_s7;

endmodule

@@ design/tln_consts.sv @@
// Configuration registers and the sequencer that derives the per-config terms.
module tln_consts import tln_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output tln_consts_t consts,
	output logic        ready
);

	typedef enum logic [8:0] {
		ST_DIV_R     = 9'b000000001,
		ST_DIV_SC    = 9'b000000010,
		ST_EXP_N     = 9'b000000100,
		ST_TAY_MUL   = 9'b000001000,
		ST_TAY_DIV   = 9'b000010000,
		ST_EXP_SH    = 9'b000100000,
		ST_LOG_SOFT  = 9'b001000000,
		ST_LOG_DELTA = 9'b010000000,
		ST_DONE      = 9'b100000000
	} tln_state_t;

	tln_state_t         state_q;
	logic               issued_q;
	logic               ready_q;
	logic [23:0]        eps_q;
	logic [31:0]        delta_q;
	logic [31:0]        sens_q;
	logic [63:0]        r_q;
	logic [63:0]        scale_q;
	logic [36:0]        red_q;
	logic [5:0]         n_q;
	logic [31:0]        y_q;
	logic [32:0]        term_q;
	logic signed [34:0] sum_q;
	logic [3:0]         k_q;
	logic [32:0]        prod_q;
	logic [32:0]        e_q;
	logic signed [63:0] soft_q;
	logic signed [63:0] num_base_q;

	logic               wr;
	logic [23:0]        e_eff;
	logic [31:0]        d_eff;
	logic [31:0]        s_eff;
	logic               div_start;
	logic [63:0]        div_dvd;
	logic [31:0]        div_dsr;
	logic               div_done;
	logic [63:0]        div_quo;
	logic               log_in_valid;
	logic [33:0]        log_x;
	logic               log_valid;
	logic signed [63:0] log_ln;
	logic [64:0]        prod_c;
	logic [33:0]        sum_pos_c;
	logic               red_ge_c;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	// Zero registers act as the smallest positive value
	assign e_eff = (eps_q == '0) ? 24'd1 : eps_q;
	assign d_eff = (delta_q == '0) ? 32'd1 : delta_q;
	assign s_eff = (sens_q == '0) ? 32'd1 : sens_q;

	// Divider operand select
	always_comb begin
		div_dvd = '0;
		div_dsr = 32'd1;
		case (state_q)
			ST_DIV_R: begin
				div_dvd = {8'b0, e_eff, 32'b0};
				div_dsr = s_eff;
			end
			ST_DIV_SC: begin
				div_dvd = {s_eff, 32'b0};
				div_dsr = {8'b0, e_eff};
			end
			ST_TAY_DIV: begin
				div_dvd = {31'b0, prod_q};
				div_dsr = {28'b0, k_q};
			end
			default: begin
				div_dvd = '0;
				div_dsr = 32'd1;
			end
		endcase
	end

	assign div_start = !wr && !issued_q &&
		(state_q == ST_DIV_R || state_q == ST_DIV_SC || state_q == ST_TAY_DIV);

	assign log_in_valid = !wr && !issued_q &&
		(state_q == ST_LOG_SOFT || state_q == ST_LOG_DELTA);
	assign log_x = (state_q == ST_LOG_SOFT) ? (34'(ONE_Q32) + 34'(e_q)) : {2'b0, d_eff};

	assign prod_c    = 65'(term_q) * 65'(y_q);
	assign sum_pos_c = sum_q[34] ? 34'd0 : sum_q[33:0];

	// Range reduction by ln 2: subtract once per cycle
	assign red_ge_c  = red_q >= {5'b0, LN2_Q32};

	tln_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_quo)
	);

	tln_log u_log (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (1'b1),
		.in_valid  (log_in_valid),
		.x         (log_x),
		.out_valid (log_valid),
		.ln        (log_ln)
	);

	// Sequencer: restart on every register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_DIV_R;
			issued_q <= 1'b0;
			ready_q  <= 1'b0;
			eps_q    <= RST_EPSILON;
			delta_q  <= RST_DELTA;
			sens_q   <= RST_SENS;
		end else if (wr) begin
			state_q  <= ST_DIV_R;
			issued_q <= 1'b0;
			ready_q  <= 1'b0;
			case (cfg_index)
				CFG_EPSILON: eps_q   <= cfg_data[23:0];
				CFG_DELTA:   delta_q <= cfg_data;
				CFG_SENS:    sens_q  <= cfg_data;
				default: ;
			endcase
		end else begin
			unique case (state_q) inside
				ST_DIV_R, ST_DIV_SC, ST_TAY_DIV,
				ST_LOG_SOFT, ST_LOG_DELTA: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (state_q == ST_LOG_SOFT || state_q == ST_LOG_DELTA) begin
						if (log_valid) begin
							issued_q <= 1'b0;
							if (state_q == ST_LOG_SOFT) begin
								state_q <= ST_LOG_DELTA;
							end else begin
								state_q <= ST_DONE;
								ready_q <= 1'b1;
							end
						end
					end else if (div_done) begin
						issued_q <= 1'b0;
						if (state_q == ST_DIV_R) begin
							state_q <= ST_DIV_SC;
						end else if (state_q == ST_DIV_SC) begin
							state_q <= (r_q >= EXP_CUTOFF) ? ST_LOG_SOFT : ST_EXP_N;
						end else begin
							state_q <= (k_q == TAYLOR_TERMS) ? ST_EXP_SH : ST_TAY_MUL;
						end
					end
				end
				ST_EXP_N: begin
					if (!red_ge_c) begin
						state_q <= ST_TAY_MUL;
					end
				end
				ST_TAY_MUL: state_q <= ST_TAY_DIV;
				ST_EXP_SH:  state_q <= ST_LOG_SOFT;
				ST_DONE:    state_q <= ST_DONE;
				default:    state_q <= ST_DIV_R;
			endcase
		end
	end

	// Datapath captures
	always_ff @(posedge clk) begin
		if (issued_q && div_done) begin
			if (state_q == ST_DIV_R) begin
				r_q <= div_quo;
			end
			if (state_q == ST_DIV_SC) begin
				scale_q <= div_quo;
				e_q     <= '0;
				red_q   <= r_q[36:0];
				n_q     <= '0;
			end
			if (state_q == ST_TAY_DIV) begin
				term_q <= div_quo[32:0];
				sum_q  <= k_q[0] ? (sum_q - $signed({2'b0, div_quo[32:0]}))
				                 : (sum_q + $signed({2'b0, div_quo[32:0]}));
				k_q    <= k_q + 4'd1;
			end
		end
		// Reduce r below ln 2, then seed the Taylor sum
		if (state_q == ST_EXP_N) begin
			if (red_ge_c) begin
				red_q <= red_q - {5'b0, LN2_Q32};
				n_q   <= n_q + 6'd1;
			end else begin
				y_q    <= red_q[31:0];
				term_q <= ONE_Q32;
				sum_q  <= 35'(ONE_Q32);
				k_q    <= 4'd1;
			end
		end
		if (state_q == ST_TAY_MUL) begin
			prod_q <= prod_c[64:32];
		end
		if (state_q == ST_EXP_SH) begin
			e_q <= 33'(sum_pos_c >> n_q);
		end
		if (issued_q && log_valid && state_q == ST_LOG_SOFT) begin
			soft_q <= log_ln;
		end
		if (issued_q && log_valid && state_q == ST_LOG_DELTA) begin
			num_base_q <= -log_ln - soft_q;
		end
	end

	assign consts.num_base = num_base_q;
	assign consts.scale    = scale_q;
	assign consts.base     = $signed({16'b0, s_eff, 16'b0}) - 64'sh1_0000_0000;
	assign ready           = ready_q;

endmodule

@@ design/tln_post.sv @@
// Scaling, shift, rounding and count add: the pipeline after the log.
module tln_post import tln_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [63:0] ln_m,
	input  tln_side_t          side,
	input  tln_consts_t        consts,
	output logic               out_valid,
	output tln_out_t           out_item
);

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [63:0] num_s1;
	logic               nneg_s2, nneg_s3, nneg_s4, nneg_s5;
	logic [63:0]        nmag_s2;
	logic [63:0]        p00_s3, p01_s3, p10_s3, p11_s3;
	logic [33:0]        mid_s4;
	logic [63:0]        hs_s4;
	logic [62:0]        sh_s5;
	logic signed [63:0] smp_s6;
	logic [31:0]        noise_s7;
	logic               sat_s7;
	logic [31:0]        cnt_s1, cnt_s2, cnt_s3, cnt_s4, cnt_s5, cnt_s6, cnt_s7;
	tln_out_t           out_s8;

	logic signed [63:0] term_c;
	logic [63:0]        hi_c;
	logic [63:0]        cat_c;
	logic [62:0]        sh_c;
	logic [64:0]        rnd_c;

	// Sign the draw term
	always_comb begin
		if (!side.nz) begin
			term_c = '0;
		end else begin
			term_c = side.uneg ? ln_m : -ln_m;
		end
	end

	// Assemble the shifted product and cap it
	always_comb begin
		hi_c  = hs_s4 + {62'b0, mid_s4[33:32]};
		cat_c = {hi_c[31:0], mid_s4[31:0]};
		if (hi_c >= 64'h4000_0000) begin
			sh_c = MAG_CAP;
		end else if (cat_c > {1'b0, MAG_CAP}) begin
			sh_c = MAG_CAP;
		end else begin
			sh_c = cat_c[62:0];
		end
		rnd_c = {1'b0, smp_s6} + 65'h8000_0000;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= consts.num_base + term_c;
			cnt_s1  <= side.count;

			nneg_s2 <= num_s1[63];
			nmag_s2 <= num_s1[63] ? 64'(-num_s1) : 64'(num_s1);
			cnt_s2  <= cnt_s1;

			p00_s3  <= {32'b0, nmag_s2[31:0]} * {32'b0, consts.scale[31:0]};
			p01_s3  <= {32'b0, nmag_s2[31:0]} * {32'b0, consts.scale[63:32]};
			p10_s3  <= {32'b0, nmag_s2[63:32]} * {32'b0, consts.scale[31:0]};
			p11_s3  <= {32'b0, nmag_s2[63:32]} * {32'b0, consts.scale[63:32]};
			nneg_s3 <= nneg_s2;
			cnt_s3  <= cnt_s2;

			mid_s4  <= {2'b0, p00_s3[63:32]} + {2'b0, p01_s3[31:0]} + {2'b0, p10_s3[31:0]};
			hs_s4   <= p11_s3 + {32'b0, p01_s3[63:32]} + {32'b0, p10_s3[63:32]};
			nneg_s4 <= nneg_s3;
			cnt_s4  <= cnt_s3;

			sh_s5   <= sh_c;
			nneg_s5 <= nneg_s4;
			cnt_s5  <= cnt_s4;

			smp_s6  <= nneg_s5 ? (consts.base - $signed({1'b0, sh_s5}))
			                   : (consts.base + $signed({1'b0, sh_s5}));
			cnt_s6  <= cnt_s5;

			// Clamp at zero, round half up, saturate
			if (smp_s6 <= 64'sd0) begin
				noise_s7 <= '0;
				sat_s7   <= 1'b0;
			end else if (rnd_c[64]) begin
				noise_s7 <= '1;
				sat_s7   <= 1'b1;
			end else begin
				noise_s7 <= rnd_c[63:32];
				sat_s7   <= 1'b0;
			end
			cnt_s7 <= cnt_s6;

			out_s8.noise_value     <= noise_s7;
			out_s8.noisy_count     <= {1'b0, cnt_s7} + {1'b0, noise_s7};
			out_s8.noise_saturated <= sat_s7;
		end
	end

	assign out_valid = v_s8;
	assign out_item  = out_s8;

endmodule

@@ design/tln_checker.sv @@
// Port-level checks for the truncated Laplace noise block, bound to the top level.
module tln_port_checks import tln_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input tln_in_t     in_item,
	input logic        out_valid,
	input logic        out_stall,
	input tln_out_t    out_item,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [31:0] cfg_data
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output transaction changed");

	// Noisy count never falls below the noise
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.noisy_count >= {1'b0, out_item.noise_value})
		else $error("noisy count below noise value");

	// Saturation only with full-scale noise
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.noise_saturated |-> out_item.noise_value == 32'hFFFF_FFFF)
		else $error("saturation flag without full-scale noise");

	// Stall input right after a register write, while terms are rederived
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("input taken right after a register write");

endmodule

bind truncated_laplace_noise_count tln_port_checks u_tln_checker (.*);
